/* hdl/wrc_pkg.sv */
// ----------------------------------------------------------------------------
// wrc_pkg: shared types and constants for the weighted roulette select table
// Table geometry, operation and status codes, entry and chain control types.
// ----------------------------------------------------------------------------
`default_nettype none

package wrc_pkg;

  localparam int unsigned MAX_ENTRIES = 32;
  localparam int unsigned WEIGHT_BITS = 16;

  localparam int unsigned ID_W        = 16;
  localparam int unsigned IN_WEIGHT_W = 16;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned CNT_OUT_W   = 6;

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  // worst-case sum of all weights fits in WEIGHT_BITS + IDX_W bits
  localparam int unsigned SUM_W = WEIGHT_BITS + IDX_W;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_SELECT = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [WEIGHT_BITS-1:0] weight;
  } entry_t;

  // control from the sequencer to the row of cells
  typedef struct packed {
    logic   shift;
    entry_t tail;
  } chain_ctl_t;

endpackage

`default_nettype wire

/* hdl/wrc_req_if.sv */
// ----------------------------------------------------------------------------
// wrc_req_if: request channel
// Valid/ready channel carrying one table operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrc_req_if;
  import wrc_pkg::*;

  logic                    valid;
  logic                    ready;
  mode_e                   mode;
  logic [ID_W-1:0]         entry_id;
  logic [IN_WEIGHT_W-1:0]  weight;
  logic [FRAC_W-1:0]       rand_frac;

  modport source (output valid, mode, entry_id, weight, rand_frac, input ready);
  modport sink   (input valid, mode, entry_id, weight, rand_frac, output ready);
endinterface

`default_nettype wire

/* hdl/wrc_rsp_if.sv */
// ----------------------------------------------------------------------------
// wrc_rsp_if: response channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrc_rsp_if;
  import wrc_pkg::*;

  logic                  valid;
  logic                  ready;
  status_e               status;
  logic [ID_W-1:0]       selected_id;
  logic [CNT_OUT_W-1:0]  entry_count;

  modport source (output valid, status, selected_id, entry_count, input ready);
  modport sink   (input valid, status, selected_id, entry_count, output ready);
endinterface

`default_nettype wire

/* hdl/weighted_roulette_select_table_core.sv */
// ----------------------------------------------------------------------------
// weighted_roulette_select_table_core: ordered (id, weight) table with
// fitness-proportional selection.
//
// req_i carries one operation per transaction: clear, append, select or
// remove by id. rsp_o returns exactly one result per request: status,
// selected id and the entry count after the operation.
// The entries live in a row of MAX_ENTRIES cells that rotate by one slot per
// cycle while a scan runs. Append, select on a non-empty table and remove walk
// the whole row once: one full rotation, then a done state that posts the
// result to the result register; no new request is taken until the sequencer
// is back in idle. Clear, append to a full table and select on an empty table
// answer the cycle after acceptance. The rotation length sets the rate.
// The select pick is floor(total * rand_frac / 65536), formed at acceptance.
// Reset empties the table (count and weight total zero); entry contents are
// not cleared. While the response is held by a stalled receiver, no new
// request is taken and a finished scan waits for the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_roulette_select_table_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wrc_req_if.sink    req_i,
  wrc_rsp_if.source  rsp_o
);
  import wrc_pkg::*;

  entry_t     cell_data [MAX_ENTRIES];
  chain_ctl_t chain;

  wrc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .head_i  (cell_data[0]),
    .next_i  (cell_data[1]),
    .chain_o (chain)
  );

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    entry_t shift_in;
    if (k == MAX_ENTRIES - 1) begin : g_tail
      assign shift_in = chain.tail;
    end else begin : g_body
      assign shift_in = cell_data[k+1];
    end

    wrc_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (chain.shift),
      .shift_in_i (shift_in),
      .data_o     (cell_data[k])
    );
  end

endmodule

`default_nettype wire

/* hdl/wrc_cell.sv */
// ----------------------------------------------------------------------------
// wrc_cell: one table slot
// Holds one (id, weight) entry and loads its shift input (the next cell's entry, or the chain tail) on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module wrc_cell (
  input  wire logic            clk_i,
  input  wire logic            shift_i,
  input  wrc_pkg::entry_t      shift_in_i,
  output wrc_pkg::entry_t      data_o
);
  import wrc_pkg::*;

  entry_t data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= shift_in_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

/* hdl/wrc_ctrl.sv */
// ----------------------------------------------------------------------------
// wrc_ctrl: operation sequencer
// Runs one rotation of the cell row per scanning operation, keeps count and
// weight total, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  wrc_req_if.sink             req_i,
  wrc_rsp_if.source           rsp_o,
  input  wrc_pkg::entry_t     head_i,
  input  wrc_pkg::entry_t     next_i,
  output wrc_pkg::chain_ctl_t chain_o
);
  import wrc_pkg::*;

  state_e                state_q, state_d;
  mode_e                 op_q, op_d;
  entry_t                key_q, key_d;
  logic [SUM_W-1:0]      pick_q, pick_d;
  logic [SUM_W-1:0]      run_q, run_d;
  logic [IDX_W-1:0]      t_q, t_d;
  logic                  found_q, found_d;
  logic [ID_W-1:0]       sel_q, sel_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [SUM_W-1:0]      total_q, total_d;

  logic                  rsp_valid_q, rsp_valid_d;
  status_e               status_q, status_d;
  logic [ID_W-1:0]       rsp_sel_q, rsp_sel_d;
  logic [CNT_OUT_W-1:0]  rsp_cnt_q, rsp_cnt_d;

  logic                  req_fire, slot_free, needs_scan;
  logic                  in_range, last_live, scan_last;
  logic                  sel_hit, rm_hit;
  logic [SUM_W-1:0]      run_sum;
  logic [SUM_W+FRAC_W-1:0] prod;
  logic [CNT_W-1:0]      t_ext;

  assign slot_free = !rsp_valid_q || rsp_o.ready;
  assign req_fire  = req_i.valid && req_i.ready;

  always_comb begin
    unique case (req_i.mode)
      MODE_APPEND: needs_scan = (count_q < CNT_W'(MAX_ENTRIES));
      MODE_SELECT: needs_scan = (count_q != '0);
      MODE_REMOVE: needs_scan = 1'b1;
      MODE_CLEAR:  needs_scan = 1'b0;
      default:     needs_scan = 1'b0;
    endcase
  end

  assign prod      = total_q * req_i.rand_frac;
  assign t_ext     = CNT_W'(t_q);
  assign in_range  = (t_ext < count_q);
  assign last_live = (t_ext == count_q - CNT_W'(1));
  assign scan_last = (t_q == IDX_W'(MAX_ENTRIES - 1));
  assign run_sum   = run_q + SUM_W'(head_i.weight);
  assign sel_hit   = (op_q == MODE_SELECT) && in_range && !found_q && (run_sum > pick_q);
  assign rm_hit    = (op_q == MODE_REMOVE) && in_range && !found_q && (head_i.id == key_q.id);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (req_fire && needs_scan) state_d = ST_SCAN;
      ST_SCAN: if (scan_last) state_d = ST_DONE;
      ST_DONE: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    pick_d      = pick_q;
    run_d       = run_q;
    t_d         = t_q;
    found_d     = found_q;
    sel_d       = sel_q;
    count_d     = count_q;
    total_d     = total_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    status_d    = status_q;
    rsp_sel_d   = rsp_sel_q;
    rsp_cnt_d   = rsp_cnt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          op_d      = req_i.mode;
          key_d     = '{id: req_i.entry_id, weight: WEIGHT_BITS'(req_i.weight)};
          pick_d    = prod[SUM_W+FRAC_W-1:FRAC_W];
          run_d     = '0;
          t_d       = '0;
          found_d   = 1'b0;
          sel_d     = '0;
          if (!needs_scan) begin
            rsp_valid_d = 1'b1;
            rsp_sel_d   = '0;
            rsp_cnt_d   = CNT_OUT_W'(count_q);
            unique case (req_i.mode)
              MODE_CLEAR: begin
                count_d   = '0;
                total_d   = '0;
                status_d  = STATUS_OK;
                rsp_cnt_d = '0;
              end
              MODE_APPEND: status_d = STATUS_FULL;
              MODE_SELECT: status_d = STATUS_EMPTY;
              default:     status_d = STATUS_OK;
            endcase
          end
        end
      end
      ST_SCAN: begin
        t_d = t_q + IDX_W'(1);
        if (in_range) begin
          run_d = run_sum;
        end
        if (sel_hit) begin
          found_d = 1'b1;
          sel_d   = head_i.id;
        end else if ((op_q == MODE_SELECT) && in_range && !found_q && last_live) begin
          sel_d = head_i.id;  // no running sum passed pick: last entry wins
        end
        if (rm_hit) begin
          found_d = 1'b1;
          total_d = total_q - SUM_W'(head_i.weight);
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          rsp_valid_d = 1'b1;
          rsp_sel_d   = '0;
          status_d    = STATUS_OK;
          rsp_cnt_d   = CNT_OUT_W'(count_q);
          unique case (op_q)
            MODE_APPEND: begin
              count_d   = count_q + CNT_W'(1);
              total_d   = total_q + SUM_W'(key_q.weight);
              rsp_cnt_d = CNT_OUT_W'(count_q + CNT_W'(1));
            end
            MODE_SELECT: rsp_sel_d = sel_q;
            MODE_REMOVE: begin
              if (found_q) begin
                count_d   = count_q - CNT_W'(1);
                rsp_cnt_d = CNT_OUT_W'(count_q - CNT_W'(1));
              end else begin
                status_d = STATUS_NOTFOUND;
              end
            end
            default: status_d = STATUS_OK;
          endcase
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready       = (state_q == ST_IDLE) && slot_free;
    rsp_o.valid       = rsp_valid_q;
    rsp_o.status      = status_q;
    rsp_o.selected_id = rsp_sel_q;
    rsp_o.entry_count = rsp_cnt_q;

    chain_o.shift = (state_q == ST_SCAN);
    chain_o.tail  = head_i;
    // append drops the new entry in right after the last live one
    if ((op_q == MODE_APPEND) && (t_ext == count_q)) begin
      chain_o.tail = key_q;
    end
    // once the removed entry is at the head, skip it by taking its follower
    if ((op_q == MODE_REMOVE) && (found_q || rm_hit)) begin
      chain_o.tail = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      rsp_valid_q <= 1'b0;
      t_q         <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      rsp_valid_q <= rsp_valid_d;
      t_q         <= t_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    pick_q    <= pick_d;
    run_q     <= run_d;
    sel_q     <= sel_d;
    status_q  <= status_d;
    rsp_sel_q <= rsp_sel_d;
    rsp_cnt_q <= rsp_cnt_d;
  end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for weighted_roulette_select_table_core
// Drives clear, append, select and remove requests with random gaps and
// back-pressure. A shadow copy of the entry table predicts status, selected id
// and entry count for every transaction, and each response is checked in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 222;

  typedef struct packed {
    status_e              status;
    logic [ID_W-1:0]      selected_id;
    logic [CNT_OUT_W-1:0] entry_count;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wrc_req_if req ();
  wrc_rsp_if rsp ();

  weighted_roulette_select_table_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the table
  logic [ID_W-1:0]        shadow_ids     [MAX_ENTRIES];
  logic [WEIGHT_BITS-1:0] shadow_weights [MAX_ENTRIES];
  int                     shadow_count = 0;
  logic [36:0]            shadow_total = '0;

  table_result_t pending_results [$];
  table_result_t got_result;
  table_result_t want_result;
  int            mismatches = 0;

  int tx_idle_max = 0;
  int rx_idle_max = 0;

  // long receiver hold-off, requested by the test and counted by the receiver
  int hold_len = 0;
  int hold_tag = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_stall = 0;

  int idle_cycles = 0;

  function automatic table_result_t apply_table_op(mode_e op, logic [ID_W-1:0] id,
                                                   logic [15:0] w, logic [15:0] frac);
    table_result_t r;
    logic [36:0]   pick;
    logic [36:0]   running;
    int            hit;
    r.status      = STATUS_OK;
    r.selected_id = '0;
    hit           = -1;
    case (op)
      MODE_CLEAR: begin
        shadow_count = 0;
        shadow_total = '0;
      end
      MODE_APPEND: begin
        if (shadow_count >= MAX_ENTRIES) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_ids[shadow_count]     = id;
          shadow_weights[shadow_count] = w[WEIGHT_BITS-1:0];
          shadow_count++;
          shadow_total += 37'(w[WEIGHT_BITS-1:0]);
        end
      end
      MODE_SELECT: begin
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          pick    = (shadow_total * 37'(frac)) >> 16;
          running = '0;
          // falls back to the last entry when no running sum passes the pick
          r.selected_id = shadow_ids[shadow_count-1];
          for (int i = 0; i < shadow_count; i++) begin
            running += 37'(shadow_weights[i]);
            if (running > pick) begin
              r.selected_id = shadow_ids[i];
              break;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_ids[i] == id) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          r.status = STATUS_NOTFOUND;
        end else begin
          shadow_total -= 37'(shadow_weights[hit]);
          for (int k = hit; k + 1 < shadow_count; k++) begin
            shadow_ids[k]     = shadow_ids[k+1];
            shadow_weights[k] = shadow_weights[k+1];
          end
          shadow_count--;
        end
      end
    endcase
    r.entry_count = CNT_OUT_W'(shadow_count);
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_op(mode_e op, logic [ID_W-1:0] id, logic [15:0] w,
                         logic [15:0] frac);
    int            gap;
    table_result_t exp_r;
    gap = $urandom_range(0, tx_idle_max);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.mode      <= op;
    req.entry_id  <= id;
    req.weight    <= w;
    req.rand_frac <= frac;
    do @(posedge clk_i); while (!req.ready);
    exp_r = apply_table_op(op, id, w, frac);
    pending_results.insert(pending_results.size(), exp_r);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic logic [15:0] pick_weight();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return 16'h0000;
    if (roll < 30) return 16'hFFFF;
    if (roll < 45) return 16'($urandom_range(0, 3));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [15:0] pick_frac();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 16'h0000;
    if (roll < 10) return 16'hFFFF;
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    // a narrow id range makes duplicates common
    if ($urandom_range(0, 1) == 0) return ID_W'($urandom_range(0, 15));
    return ID_W'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic send_random_op(int fill_target);
    int              roll;
    mode_e           op;
    logic [ID_W-1:0] id;
    roll = $urandom_range(0, 99);
    id   = pick_id();
    if (roll < 2) begin
      op = MODE_CLEAR;
    end else if (shadow_count < fill_target) begin
      op = (roll < 55) ? MODE_APPEND : (roll < 82) ? MODE_SELECT : MODE_REMOVE;
    end else begin
      op = (roll < 22) ? MODE_APPEND : (roll < 70) ? MODE_SELECT : MODE_REMOVE;
    end
    if (op == MODE_REMOVE && shadow_count != 0 && $urandom_range(0, 9) < 8)
      id = shadow_ids[$urandom_range(0, shadow_count - 1)];
    send_op(op, id, pick_weight(), pick_frac());
  endtask

  task automatic test_corner_cases();
    tx_idle_max = 3;
    rx_idle_max = 3;
    send_op(MODE_SELECT, 16'h1111, 16'h2222, 16'hFFFF);   // empty table
    send_op(MODE_REMOVE, 16'h0000, 16'h0000, 16'h0000);   // remove on empty
    send_op(MODE_APPEND, 16'h0000, 16'h0000, 16'h0000);
    send_op(MODE_SELECT, 16'h0000, 16'h0000, 16'h0000);   // all weights zero
    send_op(MODE_APPEND, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_op(MODE_SELECT, 16'h0000, 16'h0000, 16'hFFFF);   // falls to last entry
    send_op(MODE_APPEND, 16'h0005, 16'hFFFF, 16'h0000);
    send_op(MODE_APPEND, 16'h0000, 16'h0001, 16'h0000);   // duplicate id
    send_op(MODE_SELECT, 16'h0000, 16'h0000, 16'h0000);
    send_op(MODE_SELECT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_op(MODE_SELECT, 16'h0000, 16'h0000, 16'h8000);
    send_op(MODE_REMOVE, 16'h0000, 16'hFFFF, 16'hFFFF);   // first match only
    send_op(MODE_SELECT, 16'h0000, 16'h0000, 16'h0000);
    send_op(MODE_REMOVE, 16'h1234, 16'h0000, 16'h0000);   // absent id
    send_op(MODE_REMOVE, 16'h0000, 16'h0000, 16'h0000);
    send_op(MODE_SELECT, 16'h0000, 16'h0000, 16'hFFFF);
    send_op(MODE_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_op(MODE_SELECT, 16'h0000, 16'h0000, 16'h0001);
    send_op(MODE_REMOVE, 16'hFFFF, 16'h0000, 16'h0000);
    send_op(MODE_APPEND, 16'hAAAA, 16'h5555, 16'h0000);
    send_op(MODE_SELECT, 16'h5555, 16'hAAAA, 16'h0001);
    send_op(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_full_table();
    tx_idle_max = 0;
    rx_idle_max = 0;
    for (int i = 0; i < MAX_ENTRIES; i++)
      send_op(MODE_APPEND, ID_W'(i * 16'h0801 + 1), 16'hFFFF, 16'h0000);
    send_op(MODE_APPEND, 16'hBEEF, 16'h0001, 16'h0000);   // table full
    send_op(MODE_SELECT, 16'h0000, 16'h0000, 16'h0000);
    send_op(MODE_SELECT, 16'h0000, 16'h0000, 16'hFFFF);
    send_op(MODE_SELECT, 16'h0000, 16'h0000, 16'h8000);
    send_op(MODE_REMOVE, ID_W'((MAX_ENTRIES - 1) * 16'h0801 + 1), 16'h0000, 16'h0000);
    send_op(MODE_APPEND, 16'hCAFE, 16'h0000, 16'h0000);
    send_op(MODE_APPEND, 16'hF00D, 16'h0000, 16'h0000);
    send_op(MODE_REMOVE, 16'h0001, 16'h0000, 16'h0000);
    send_op(MODE_SELECT, 16'h0000, 16'h0000, 16'hFFFF);
    send_op(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_backpressure();
    tx_idle_max = 0;
    rx_idle_max = 0;
    send_op(MODE_APPEND, 16'h0042, 16'h0010, 16'h0000);
    hold_len <= 300;
    hold_tag <= hold_tag + 1;
    // the block holds one result and stops taking requests until released
    for (int i = 0; i < 8; i++)
      send_random_op(8);
    wait_drained();
    send_op(MODE_SELECT, 16'h0000, 16'h0000, 16'h4000);
    send_op(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_traffic();
    int target;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_max = 0;  rx_idle_max = 0;  end
        1: begin tx_idle_max = 16; rx_idle_max = 2;  end
        2: begin tx_idle_max = 2;  rx_idle_max = 16; end
        default: begin tx_idle_max = 16; rx_idle_max = 16; end
      endcase
      target = (p % 3 == 0) ? MAX_ENTRIES : $urandom_range(1, 12);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_random_op(target);
    end
  endtask

  // receiver: random stall after each result, plus long hold-off on request
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (rsp.valid && rsp.ready)
          rx_stall = $urandom_range(0, rx_idle_max);
        else if (rx_stall > 0)
          rx_stall--;
        if (hold_tag != hold_seen) begin
          hold_seen = hold_tag;
          hold_left = hold_len;
        end
        if (hold_left > 0) begin
          hold_left--;
          rsp.ready <= 1'b0;
        end else begin
          rsp.ready <= (rx_stall == 0);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      got_result.status      = rsp.status;
      got_result.selected_id = rsp.selected_id;
      got_result.entry_count = rsp.entry_count;
      if (pending_results.size() == 0) begin
        $error("response transaction with nothing outstanding");
        mismatches++;
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.status !== want_result.status) begin
          $error("status: expected %0d, got %0d", want_result.status, got_result.status);
          mismatches++;
        end
        if (got_result.selected_id !== want_result.selected_id) begin
          $error("selected_id: expected %h, got %h",
                 want_result.selected_id, got_result.selected_id);
          mismatches++;
        end
        if (got_result.entry_count !== want_result.entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 want_result.entry_count, got_result.entry_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    req.valid     = 1'b0;
    req.mode      = MODE_CLEAR;
    req.entry_id  = '0;
    req.weight    = '0;
    req.rand_frac = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_cases();
    test_full_table();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (MAX_ENTRIES + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/wrc_pkg.sv
hdl/wrc_req_if.sv
hdl/wrc_rsp_if.sv
hdl/wrc_cell.sv
hdl/wrc_ctrl.sv
hdl/weighted_roulette_select_table_core.sv
tb/sv/tb.sv
